### hdl/ttd_pkg.sv
// ---------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants for the tick task dispatcher: word layouts,
// slot entry layout, mode and kind codes, and sequencer-to-unit structs.
// ---------------------------------------------------------------------------
package ttd_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int SCAN_W     = $clog2(TASK_SLOTS + 1);

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] KIND_PERIODIC  = 2'd0;
    localparam logic [1:0] KIND_ONESHOT   = 2'd1;
    localparam logic [1:0] KIND_SUSPENDED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [1:0]  task_kind;
        logic [15:0] reload_value;
        logic [15:0] start_count;
    } in_word_t;

    typedef struct packed {
        logic       dispatched;
        logic [3:0] task_slot;
        logic       task_retired;
    } out_word_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [COUNT_BITS-1:0] reload;
        logic [COUNT_BITS-1:0] countdown;
    } slot_entry_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] addr;
        slot_entry_t           entry;
    } mem_wr_t;

    typedef struct packed {
        slot_entry_t cur;
        logic        valid;
        logic        target;
    } alu_req_t;

    typedef struct packed {
        logic        wr_en;
        slot_entry_t entry;
        logic        clear_valid;
        logic        dispatched;
        logic        retired;
    } alu_res_t;

endpackage

### hdl/ttd_slot_mem.sv
// ---------------------------------------------------------------------------
// ttd_slot_mem
// Slot table storage: kind, reload and countdown per slot. One write port
// and one read port with registered read data.
// ---------------------------------------------------------------------------
module ttd_slot_mem (
    input  logic                          aclk,
    input  ttd_pkg::mem_wr_t              wr,
    input  logic [ttd_pkg::SLOT_IDX_W-1:0] rd_addr,
    output ttd_pkg::slot_entry_t          rd_data
);
    import ttd_pkg::*;

    slot_entry_t mem [TASK_SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/ttd_slot_alu.sv
// ---------------------------------------------------------------------------
// ttd_slot_alu
// Shared update unit applied to one slot per cycle during a tick sweep:
// acts on the reached task at zero countdown and decrements the countdown.
// ---------------------------------------------------------------------------
module ttd_slot_alu (
    input  ttd_pkg::alu_req_t req,
    output ttd_pkg::alu_res_t res
);
    import ttd_pkg::*;

    logic                  act;
    logic                  do_reload;
    logic                  do_retire;
    logic                  do_resume;
    logic                  keep;
    logic [COUNT_BITS-1:0] operand;

    always_comb begin
        act       = req.target && (req.cur.countdown == '0);
        do_reload = act && (req.cur.kind == KIND_PERIODIC);
        do_retire = act && (req.cur.kind == KIND_ONESHOT);
        do_resume = act && (req.cur.kind == KIND_SUSPENDED);
        keep      = req.valid && !do_retire;

        // A reloaded periodic task is decremented in the same tick.
        operand = do_reload ? req.cur.reload : req.cur.countdown;

        res.entry.reload    = req.cur.reload;
        res.entry.kind      = do_resume ? KIND_PERIODIC : req.cur.kind;
        res.entry.countdown = (keep && (operand != '0)) ? operand - 1'b1 : operand;
        res.wr_en           = keep;
        res.clear_valid     = do_retire;
        res.dispatched      = do_reload || do_retire;
        res.retired         = do_retire;
    end

endmodule

### hdl/ttd_sequencer.sv
// ---------------------------------------------------------------------------
// ttd_sequencer
// Control for the dispatcher: valid bits, scan position, item decode, the
// slot sweep that drives the shared update unit, and the result register.
// ---------------------------------------------------------------------------
module ttd_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ttd_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ttd_pkg::out_word_t             m_data,
    output ttd_pkg::mem_wr_t               mem_wr,
    output logic [ttd_pkg::SLOT_IDX_W-1:0] mem_rd_addr,
    input  ttd_pkg::slot_entry_t           mem_rd_data,
    output ttd_pkg::alu_req_t              alu_req,
    input  ttd_pkg::alu_res_t              alu_res
);
    import ttd_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                  state_reg;
    logic [TASK_SLOTS-1:0] valid_reg;
    logic [SCAN_W-1:0]     scan_pos_reg;
    logic [SCAN_W-1:0]     cnt_reg;
    logic                  proc_vld_reg;
    logic [SLOT_IDX_W-1:0] proc_idx_reg;
    logic                  found_reg;
    logic                  disp_reg;
    logic [3:0]            tslot_reg;
    logic                  ret_reg;
    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    logic                  accept;
    logic                  ack_load;
    logic                  in_range;
    logic [SLOT_IDX_W-1:0] item_idx;
    logic                  target;
    logic                  last;
    out_word_t             result;

    always_comb begin
        s_ready     = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        accept      = s_valid && s_ready;
        ack_load    = accept && (s_data.mode != MODE_TICK);
        in_range    = 32'(s_data.slot) < TASK_SLOTS;
        item_idx    = SLOT_IDX_W'(s_data.slot);
        mem_rd_addr = SLOT_IDX_W'(cnt_reg);

        // The first valid slot at or after the scan position is the one reached.
        target = proc_vld_reg && valid_reg[proc_idx_reg] && !found_reg
                 && (SCAN_W'(proc_idx_reg) >= scan_pos_reg);

        alu_req.cur    = mem_rd_data;
        alu_req.valid  = proc_vld_reg && valid_reg[proc_idx_reg];
        alu_req.target = target;

        mem_wr = '0;
        if (state_reg == ST_IDLE) begin
            if (accept && (s_data.mode == MODE_WRITE) && in_range) begin
                mem_wr.en              = 1'b1;
                mem_wr.addr            = item_idx;
                mem_wr.entry.kind      = s_data.task_kind;
                mem_wr.entry.reload    = COUNT_BITS'(s_data.reload_value);
                mem_wr.entry.countdown = COUNT_BITS'(s_data.start_count);
            end
        end else if (proc_vld_reg) begin
            mem_wr.en    = alu_res.wr_en;
            mem_wr.addr  = proc_idx_reg;
            mem_wr.entry = alu_res.entry;
        end

        last = proc_vld_reg && (proc_idx_reg == SLOT_IDX_W'(TASK_SLOTS - 1));

        result.dispatched   = disp_reg || alu_res.dispatched;
        result.task_slot    = alu_res.dispatched ? 4'(proc_idx_reg) : tslot_reg;
        result.task_retired = ret_reg || alu_res.retired;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            scan_pos_reg <= '0;
            cnt_reg      <= '0;
            proc_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !ack_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg      <= '0;
                    proc_vld_reg <= 1'b0;
                    if (accept) begin
                        case (s_data.mode)
                            MODE_TICK: begin
                                state_reg <= ST_SWEEP;
                                found_reg <= 1'b0;
                                disp_reg  <= 1'b0;
                                tslot_reg <= '0;
                                ret_reg   <= 1'b0;
                            end
                            MODE_WRITE: begin
                                if (in_range) begin
                                    valid_reg[item_idx] <= 1'b1;
                                end
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '0;
                            end
                            MODE_REMOVE: begin
                                if (in_range) begin
                                    valid_reg[item_idx] <= 1'b0;
                                end
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '0;
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '0;
                            end
                        endcase
                    end
                end
                ST_SWEEP: begin
                    // Reads run one slot ahead of the write-back.
                    if (cnt_reg < SCAN_W'(TASK_SLOTS)) begin
                        cnt_reg      <= cnt_reg + 1'b1;
                        proc_vld_reg <= 1'b1;
                        proc_idx_reg <= SLOT_IDX_W'(cnt_reg);
                    end else begin
                        proc_vld_reg <= 1'b0;
                    end
                    if (proc_vld_reg) begin
                        if (alu_res.clear_valid) begin
                            valid_reg[proc_idx_reg] <= 1'b0;
                        end
                        if (target) begin
                            found_reg    <= 1'b1;
                            scan_pos_reg <= SCAN_W'(proc_idx_reg) + SCAN_W'(1);
                        end
                        if (alu_res.dispatched) begin
                            disp_reg  <= 1'b1;
                            tslot_reg <= 4'(proc_idx_reg);
                            ret_reg   <= alu_res.retired;
                        end
                        if (last) begin
                            state_reg   <= ST_IDLE;
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= result;
                            if (!found_reg && !target) begin
                                scan_pos_reg <= '0;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/tick_task_dispatcher.sv
// ---------------------------------------------------------------------------
// tick_task_dispatcher
// Timer-tick task dispatcher over a table of task slots, built as a slot
// sweep through one shared update unit under a small sequencer.
// ---------------------------------------------------------------------------
// Channel   Ports                       Word
// input     s_valid, s_ready, s_data    mode, slot, kind, reload, start count
// result    m_valid, m_ready, m_data    dispatched, task slot, retired flag
//
// A write, remove or unused-mode word yields its result word on the cycle
// after it is accepted. During a tick, the sweep reads one slot table entry
// per cycle through the single memory read port and writes it back in the
// cycle after the read. No clearing pass follows reset. Input ready stays
// low during a sweep and while an undelivered result word would block the
// next one.
// ---------------------------------------------------------------------------
module tick_task_dispatcher (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ttd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ttd_pkg::out_word_t m_data
);
    import ttd_pkg::*;

    mem_wr_t               mem_wr;
    logic [SLOT_IDX_W-1:0] mem_rd_addr;
    slot_entry_t           mem_rd_data;
    alu_req_t              alu_req;
    alu_res_t              alu_res;

    ttd_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .alu_req     (alu_req),
        .alu_res     (alu_res)
    );

    ttd_slot_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ttd_slot_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

endmodule

### hdl/ttd_checker.sv
// ---------------------------------------------------------------------------
// ttd_checker
// Port-level checks for the tick task dispatcher, bound to the top level.
// ---------------------------------------------------------------------------
module ttd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ttd_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input ttd_pkg::out_word_t m_data
);
    import ttd_pkg::*;

    // A result word stays offered until it is taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped before it was taken");

    // Retirement only ever accompanies a dispatch.
    a_retire_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.task_retired || m_data.dispatched))
        else $error("retired flag without dispatch");

    // A result word without a dispatch, such as from an idle tick, reports slot zero.
    a_idle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.dispatched) |-> (m_data.task_slot == 4'd0))
        else $error("nonzero slot on an idle result word");

    // A tick starts a sweep: no new word taken and no result on the next cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.mode == MODE_TICK)) |=> (!s_ready && !m_valid))
        else $error("tick word did not start a sweep");

    // A slot write answers on the next cycle with an empty result.
    a_write_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.mode == MODE_WRITE))
            |=> (m_valid && !m_data.dispatched && !m_data.task_retired))
        else $error("slot write not answered with an empty result");

endmodule

bind tick_task_dispatcher ttd_checker u_ttd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
